// ----- rtl/epmc_pkg.sv -----
// Shared types and constants for the exact pattern match counter.
// No dependencies; every other file in rtl imports this package.
package epmc_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int MIN_PATTERN = 5;
  localparam int PAT_BYTES   = 32;
  localparam int NUM_WORDS   = PAT_BYTES / 8;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int PAT_IDX_W   = $clog2(PAT_BYTES);
  localparam int LEN_W       = 6;
  localparam int COUNT_W     = 32;
  localparam int WORD_W      = 64;
  localparam int ADDR_W      = 6;
  localparam int IN_W        = 8;
  localparam int OUT_W       = 40;
  localparam int PAD_W       = OUT_W - COUNT_W - 1;

  localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(5);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    REG_LENGTH = 3'd0,
    REG_WORD0  = 3'd1,
    REG_WORD1  = 3'd2,
    REG_WORD2  = 3'd3,
    REG_WORD3  = 3'd4
  } reg_index_t;

  typedef logic [PAT_BYTES-1:0][7:0] pattern_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    pattern_t         pattern;
  } cfg_t;

  typedef struct packed {
    logic               match;
    logic [COUNT_W-1:0] count;
    logic               done;
  } result_t;

endpackage

// ----- rtl/epmc_regs.sv -----
// APB register file holding the pattern length and the four pattern words.
// Depends on epmc_pkg for the register map and the cfg_t bundle.
module epmc_regs import epmc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0] pwdata,
  output logic [WORD_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [LEN_W-1:0]                 pattern_length;
  logic [NUM_WORDS-1:0][WORD_W-1:0] pattern_words;
  reg_index_t                       reg_sel;
  logic                             wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[ADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_RESET;
      pattern_words  <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_LENGTH: pattern_length   <= pwdata[LEN_W-1:0];
        REG_WORD0:  pattern_words[0] <= pwdata;
        REG_WORD1:  pattern_words[1] <= pwdata;
        REG_WORD2:  pattern_words[2] <= pwdata;
        REG_WORD3:  pattern_words[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LENGTH: prdata = WORD_W'(pattern_length);
      REG_WORD0:  prdata = pattern_words[0];
      REG_WORD1:  prdata = pattern_words[1];
      REG_WORD2:  prdata = pattern_words[2];
      REG_WORD3:  prdata = pattern_words[3];
      default:    prdata = '0;
    endcase
  end

  assign cfg.len     = pattern_length;
  assign cfg.pattern = pattern_t'(pattern_words);

endmodule

// ----- rtl/epmc_cell.sv -----
// One window cell: holds a text byte and its valid bit, passes them on.
// Depends on epmc_pkg for widths and the pattern type.
module epmc_cell import epmc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic             clear,
  input  logic [IDX_W-1:0] pos,
  input  logic [LEN_W-1:0] len,
  input  pattern_t         pattern,
  input  logic [7:0]       byte_in,
  input  logic             valid_in,
  output logic [7:0]       byte_out,
  output logic             valid_out,
  output logic             ok
);

  logic [LEN_W-1:0] pos_ext;
  logic [LEN_W-1:0] pidx;
  logic [7:0]       pbyte;

  // The cell at window position pos lines up with pattern byte len-1-pos.
  assign pos_ext = LEN_W'(pos);
  assign pidx    = len - LEN_W'(1) - pos_ext;

  always_comb begin
    if (pidx >= LEN_W'(PAT_BYTES)) begin
      pbyte = 8'h00;
    end else begin
      pbyte = pattern[pidx[PAT_IDX_W-1:0]];
    end
  end

  // The check looks at the byte that moves in on this shift.
  assign ok = (pos_ext >= len) || (valid_in && (byte_in == pbyte));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (clear) begin
      valid_out <= 1'b0;
    end else if (shift) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      byte_out <= byte_in;
    end
  end

endmodule

// ----- rtl/exact_pattern_match_counter.sv -----
// Top level of the exact pattern match counter: register file, cell chain,
// occurrence counter and output buffer. Depends on epmc_pkg, epmc_regs, epmc_cell.
//
// Usage: text bytes stream in on the s_ channel, one item per byte, with
// s_tlast on the final byte of a text. For every item exactly one result
// item leaves on the m_ channel: whether an occurrence of the pattern ends
// at that byte, the running saturating occurrence count, and m_tlast copied
// from the input. Overlapping occurrences all count.
// The pattern and its length (5 to 32 bytes) are set over the APB port at
// byte addresses 0 (length) and 8, 16, 24, 32 (pattern words).
// A result is registered in the output buffer when its byte is accepted.
// Throughput: one byte per cycle while s_tready is high; the whole window compare, its AND tree
// and the count increment sit in the single cycle of the accept.
// The window is a chain of 32 cells that shift one step per accepted byte;
// each cell compares its incoming byte with the pattern byte lined up with it.
// Reset clears the window, the count and sets the length to 5 and the
// pattern to zero. After a final byte the window and the count clear.
// When the receiver stalls, a second result is held in a skid register and
// s_tready drops only once both output entries are full.
module exact_pattern_match_counter import epmc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0] pwdata,
  output logic [WORD_W-1:0] prdata,
  output logic              pready,
  // Input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // [7:0] text_byte
  input  logic              s_tlast,   // last_byte
  // Output stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // [0] match_here, [32:1] match_count, rest zero
  output logic              m_tlast    // text_done
);

  cfg_t cfg;

  epmc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic s_accept;
  logic m_accept;

  assign s_accept = s_tvalid && s_tready;
  assign m_accept = m_tvalid && m_tready;

  // Window cells. Cell 0 takes the new byte; cell k takes what cell k-1 held.
  logic [MAX_PATTERN-1:0][7:0] win_byte;
  logic [MAX_PATTERN-1:0]      win_valid;
  logic [MAX_PATTERN-1:0]      cell_ok;

  genvar k;
  generate
    for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
      logic [7:0] byte_in;
      logic       valid_in;
      if (k == 0) begin : g_head
        assign byte_in  = s_tdata[7:0];
        assign valid_in = 1'b1;
      end else begin : g_body
        assign byte_in  = win_byte[k-1];
        assign valid_in = win_valid[k-1];
      end
      epmc_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (s_accept),
        .clear     (s_accept && s_tlast),
        .pos       (IDX_W'(k)),
        .len       (cfg.len),
        .pattern   (cfg.pattern),
        .byte_in   (byte_in),
        .valid_in  (valid_in),
        .byte_out  (win_byte[k]),
        .valid_out (win_valid[k]),
        .ok        (cell_ok[k])
      );
    end
  endgenerate

  // A length outside the supported range never matches.
  logic               len_ok;
  logic               hit;
  logic [COUNT_W-1:0] occurrences;
  logic [COUNT_W-1:0] occurrences_next;

  assign len_ok = (cfg.len >= LEN_W'(MIN_PATTERN)) &&
                  ({1'b0, cfg.len} <= (LEN_W + 1)'(MAX_PATTERN));
  assign hit    = len_ok && (&cell_ok);

  always_comb begin
    if (hit && (occurrences != COUNT_MAX)) begin
      occurrences_next = occurrences + COUNT_W'(1);
    end else begin
      occurrences_next = occurrences;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occurrences <= '0;
    end else if (s_accept) begin
      occurrences <= s_tlast ? '0 : occurrences_next;
    end
  end

  // Two-entry output buffer: the main register drives the port, the skid
  // register catches one more result while the receiver stalls.
  result_t res;
  result_t out_data;
  result_t skid_data;
  logic    out_valid;
  logic    skid_valid;

  assign res.match = hit;
  assign res.count = occurrences_next;
  assign res.done  = s_tlast;

  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_accept) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= s_accept;
      end
    end else if (s_accept) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_accept) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (s_accept) begin
        out_data <= res;
      end
    end else if (s_accept) begin
      if (out_valid) begin
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_W{1'b0}}, out_data.count, out_data.match};
  assign m_tlast  = out_data.done;

`ifndef NO_ASSERTIONS
  // The skid entry is only ever filled behind a waiting main entry.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid without main entry");

  // Input backpressure only follows a stalled output.
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> $past(out_valid && !m_tready))
    else $error("input stalled without output stall");

  // A reported occurrence always comes with a nonzero count.
  a_match_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[COUNT_W:1] != '0))
    else $error("match reported with zero count");

  // The end of a text clears the window and the count.
  a_text_clear: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_tlast) |=> ((occurrences == '0) && (win_valid == '0)))
    else $error("window or count not cleared after final byte");
`endif

endmodule
